[rtl/b64wc_pkg.sv]
// ----------------------------------------------------------------------------
// b64wc_pkg
// Shared types, the symbol word table and the table lookup functions of the
// base64 word substitution codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64wc_pkg;

  localparam int SymBits   = 6;
  localparam int TableSize = 64;
  localparam int WordBits  = 48;

  typedef logic [SymBits-1:0]  sym_t;
  typedef logic [WordBits-1:0] word_t;

  // One result as it leaves the block.
  typedef struct packed {
    word_t value;
    logic  last;
    logic  err;
  } entry_t;

  // All results caused by one request; count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    entry_t     slot0;
    entry_t     slot1;
  } res_t;

  // Each word is two BMP code points, first one in the upper half.
  localparam logic [31:0] CP_TABLE [TableSize] = '{
    32'h5982_6765, 32'h83E9_8428, 32'h7F57_6C49, 32'h822C_82E5,
    32'h83E9_63D0, 32'h6D85_69C3, 32'h4E09_6627, 32'h7985_5B9A,
    32'h6148_60B2, 32'h559C_820D, 32'h89E3_8131, 32'h81EA_5728,
    32'h89C2_7167, 32'h4FEE_884C, 32'h7CBE_8FDB, 32'h5E03_65BD,
    32'h6301_6212, 32'h5FCD_8FB1, 32'h7985_90A3, 32'h667A_6167,
    32'h65B9_4FBF, 32'h613F_529B, 32'h529F_5FB7, 32'h798F_7530,
    32'h7F18_8D77, 32'h6027_7A7A, 32'h4F17_751F, 32'h4F5B_6027,
    32'h6CD5_8EAB, 32'h62A5_8EAB, 32'h5316_8EAB, 32'h771F_5982,
    32'h5B9E_9645, 32'h6CD5_754C, 32'h771F_8C1B, 32'h4FD7_8C1B,
    32'h4E2D_9053, 32'h5B9E_76F8, 32'h65E0_660E, 32'h884C_8BC6,
    32'h540D_8272, 32'h516D_5165, 32'h89E6_53D7, 32'h7231_53D6,
    32'h6709_751F, 32'h8001_6B7B, 32'h82E6_96C6, 32'h706D_9053,
    32'h56DB_8C1B, 32'h516B_6B63, 32'h56E0_7F18, 32'h9053_54C1,
    32'h865A_7A7A, 32'h4E00_4E58, 32'h4E8C_8C1B, 32'h4E09_5B9D,
    32'h56DB_5FF5, 32'h4E94_6839, 32'h516D_5C18, 32'h4E03_5B9D,
    32'h516B_98CE, 32'h4E5D_54C1, 32'h5341_529B, 32'h767E_52AB
  };

  // Three-byte UTF-8 form of a BMP code point.
  function automatic logic [23:0] utf8_3(input logic [15:0] cp);
    return {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
  endfunction

  function automatic word_t word_of(input sym_t sym);
    logic [31:0] cps;
    cps = CP_TABLE[sym];
    return {utf8_3(cps[31:16]), utf8_3(cps[15:0])};
  endfunction

  // Parallel compare against every table word. The words are distinct, so
  // at most one compare hits and the index is an OR of the hits.
  function automatic logic [SymBits:0] find_symbol(input word_t w);
    logic hit;
    sym_t idx;
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < TableSize; i++) begin
      if (word_of(sym_t'(i)) == w) begin
        hit = 1'b1;
        idx = idx | sym_t'(i);
      end
    end
    return {hit, idx};
  endfunction

endpackage

`default_nettype wire

[rtl/b64wc_step.sv]
// ----------------------------------------------------------------------------
// b64wc_step
// Stream state (group phase, carried bits, drop flag) and the single-pass
// logic that turns one request into its results.
// ----------------------------------------------------------------------------
`default_nettype none

module b64wc_step
  import b64wc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        fire,
  input  wire word_t       item_value,
  input  wire logic        item_last,
  output res_t             res
);

  logic       direction;
  logic [1:0] phase;
  sym_t       carry_bits;
  logic       dropping;

  logic [1:0] phase_next;
  sym_t       carry_bits_next;
  logic       dropping_next;

  logic       hit;
  sym_t       idx;
  logic [7:0] b;
  sym_t       sym0;
  sym_t       sym1;

  assign {hit, idx} = find_symbol(item_value);
  assign b = item_value[7:0];

  always_comb begin
    res             = '0;
    phase_next      = phase;
    carry_bits_next = carry_bits;
    dropping_next   = dropping;
    sym0            = '0;
    sym1            = '0;
    if (dropping) begin
      if (item_last) begin
        dropping_next = 1'b0;
        phase_next      = '0;
        carry_bits_next = '0;
      end
    end else if (!direction) begin
      // Encode: one or two symbols from this byte, plus a flush on the last.
      case (phase)
        2'd0: begin
          sym0            = b[7:2];
          carry_bits_next = {b[1:0], 4'b0000};
          phase_next      = 2'd1;
          res.count       = 2'd1;
        end
        2'd1: begin
          sym0            = carry_bits | {2'b00, b[7:4]};
          carry_bits_next = {b[3:0], 2'b00};
          phase_next      = 2'd2;
          res.count       = 2'd1;
        end
        default: begin
          sym0            = carry_bits | {4'b0000, b[7:6]};
          sym1            = b[5:0];
          carry_bits_next = '0;
          phase_next      = 2'd0;
          res.count       = 2'd2;
        end
      endcase
      if (item_last && phase_next != 2'd0) begin
        sym1      = carry_bits_next;
        res.count = 2'd2;
      end
      res.slot0.value = word_of(sym0);
      res.slot1.value = word_of(sym1);
      res.slot0.last  = item_last && (res.count == 2'd1);
      res.slot1.last  = item_last && (res.count == 2'd2);
      if (item_last) begin
        phase_next      = '0;
        carry_bits_next = '0;
      end
    end else begin
      // Decode: one symbol in, at most one byte out.
      if (!hit) begin
        res.count       = 2'd1;
        res.slot0.last  = 1'b1;
        res.slot0.err   = 1'b1;
        phase_next      = '0;
        carry_bits_next = '0;
        dropping_next   = !item_last;
      end else begin
        case (phase)
          2'd0: begin
            if (item_last) begin
              res.count      = 2'd1;
              res.slot0.last = 1'b1;
              res.slot0.err  = 1'b1;
            end
            carry_bits_next = idx;
            phase_next      = 2'd1;
          end
          2'd1: begin
            res.count             = 2'd1;
            res.slot0.value[7:0]  = {carry_bits, idx[5:4]};
            carry_bits_next       = {2'b00, idx[3:0]};
            phase_next            = 2'd2;
          end
          2'd2: begin
            res.count             = 2'd1;
            res.slot0.value[7:0]  = {carry_bits[3:0], idx[5:2]};
            carry_bits_next       = {4'b0000, idx[1:0]};
            phase_next            = 2'd3;
          end
          default: begin
            res.count             = 2'd1;
            res.slot0.value[7:0]  = {carry_bits[1:0], idx};
            carry_bits_next       = '0;
            phase_next            = 2'd0;
          end
        endcase
        if (res.count != 2'd0 && !res.slot0.err) begin
          res.slot0.last = item_last;
        end
        if (item_last) begin
          phase_next      = '0;
          carry_bits_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      phase      <= '0;
      carry_bits <= '0;
      dropping   <= 1'b0;
    end else if (cfg_write) begin
      direction  <= cfg_data;
      phase      <= '0;
      carry_bits <= '0;
      dropping   <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      carry_bits <= carry_bits_next;
      dropping   <= dropping_next;
    end
  end

endmodule

`default_nettype wire

[rtl/b64wc_outbuf.sv]
// ----------------------------------------------------------------------------
// b64wc_outbuf
// Two-slot result register. It loads all results of one request at once and
// hands them out one per accepted output request.
// ----------------------------------------------------------------------------
`default_nettype none

module b64wc_outbuf
  import b64wc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load,
  input  wire res_t  res,
  input  wire logic  out_stall,
  output logic       can_load,
  output logic       out_valid,
  output word_t      out_value,
  output logic       out_last,
  output logic       error
);

  logic [1:0] count;
  entry_t     slot0;
  entry_t     slot1;
  logic       take;

  assign out_valid = (count != 2'd0);
  assign take      = out_valid && !out_stall;
  // Free once the last held result leaves in this cycle.
  assign can_load  = (count == 2'd0) || (count == 2'd1 && take);

  assign out_value = slot0.value;
  assign out_last  = slot0.last;
  assign error     = slot0.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= res.count;
    end else if (take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res.slot0;
      slot1 <= res.slot1;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

[rtl/base64_word_substitution_codec.sv]
// ----------------------------------------------------------------------------
// base64_word_substitution_codec
// Streaming codec between bytes and 48-bit table words carrying unpadded
// base64 symbols, in either direction chosen by one register.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                               Direction  Flow
//   in       in_valid, in_stall, item_value/last   sink       valid/stall
//   out      out_valid, out_stall, out_value/      source     valid/stall
//            out_last, error
//   cfg      cfg_write, cfg_data (direction)       sink       write only
//
// A request waits in the input register, then the step logic computes its
// zero, one or two results in one pass into the two-slot result register.
// A request is accepted every cycle while out_stall is low and each yields at
// most one; one with two results holds the result register till both leave.
// Reset is synchronous and clears the stream state and the direction (encode).
// Output stalls back up into in_stall through the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_word_substitution_codec
  import b64wc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write,
  input  wire logic  cfg_data,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire word_t item_value,
  input  wire logic  item_last,
  output logic       out_valid,
  input  wire logic  out_stall,
  output word_t      out_value,
  output logic       out_last,
  output logic       error
);

  // Input register holding one request until the result register frees.
  logic  in_full;
  word_t in_value;
  logic  in_last;

  logic  can_load;
  logic  fire;
  logic  in_take;
  res_t  res;

  assign fire     = in_full && can_load;
  assign in_stall = in_full && !can_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_value <= item_value;
      in_last  <= item_last;
    end
  end

  // The step logic owns the stream state and the direction register.
  b64wc_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .fire       (fire),
    .item_value (in_value),
    .item_last  (in_last),
    .res        (res)
  );

  // Result register: both results of a request land together and drain
  // one per cycle while out_stall is low.
  b64wc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_last  (out_last),
    .error     (error)
  );

`ifndef SYNTHESIS
  // A request never produces more than two results.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fire |-> res.count != 2'd3)
    else $error("step produced an invalid result count");

  // Every error result closes its message.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> out_last)
    else $error("error result without last flag");

  // With two results, only the second one can carry the last flag.
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    fire && res.count == 2'd2 |-> !res.slot0.last)
    else $error("last flag on the first of two results");

  // Two loaded results keep the output busy in the next cycle too.
  a_pair_drain: assert property (@(posedge clk) disable iff (rst)
    fire && res.count == 2'd2 |=> out_valid)
    else $error("second result lost");
`endif

endmodule

`default_nettype wire
